FILE: src/ipfd_pkg.sv
// Shared types, codes and helpers of the IPv4 forwarding engine with duplicate filter.
package ipfd_pkg;

  localparam int CACHE_ENTRIES_DEF = 2;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam logic [15:0] HOLD_TICKS_RST  = 16'd20;
  localparam logic [15:0] CSUM_TTL_STEP   = 16'h0100;
  localparam logic [15:0] CSUM_WRAP_LIMIT = 16'hfeff;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ   = 8'd8;

  typedef enum logic [1:0] {
    FUNC_FORWARD = 2'd0,
    FUNC_OUTPUT  = 2'd1,
    FUNC_TICK    = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_LOCAL   = 3'd0,
    ST_SENT    = 3'd1,
    ST_DUP     = 3'd2,
    ST_NOROUTE = 3'd3,
    ST_ZEROLEN = 3'd4,
    ST_SILENT  = 3'd5,
    ST_TICK    = 3'd6,
    ST_IGNORED = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    IFACE_ROUTE0  = 2'd0,
    IFACE_ROUTE1  = 2'd1,
    IFACE_DEFAULT = 2'd2,
    IFACE_NONE    = 2'd3
  } iface_t;

  typedef enum logic [2:0] {
    CFG_HOST_ADDR   = 3'd0,
    CFG_ROUTE0_NET  = 3'd1,
    CFG_ROUTE0_MASK = 3'd2,
    CFG_ROUTE1_NET  = 3'd3,
    CFG_ROUTE1_MASK = 3'd4,
    CFG_ROUTE_EN    = 3'd5,
    CFG_HOLD_TICKS  = 3'd6,
    CFG_PING_CONF   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] host_addr;
    logic [31:0] route0_net;
    logic [31:0] route0_mask;
    logic [31:0] route1_net;
    logic [31:0] route1_mask;
    logic [2:0]  route_enable;
    logic [15:0] hold_ticks;
    logic        ping_addr_conf;
  } cfg_t;

  // Everything that identifies a packet for the duplicate filter.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] pkt_len;
    logic [15:0] frag_offset;
    logic [15:0] ip_ident;
    logic [7:0]  protocol;
    logic [31:0] port_word;
  } key_t;

  // Classified item, front to back.
  typedef struct packed {
    logic        tick;
    logic        check_dup;
    logic        record;
    status_t     status;
    logic        send;
    logic [1:0]  iface;
    logic        tex;
    logic [7:0]  ttl_out;
    logic [15:0] csum_out;
    logic [7:0]  ttl_in;
    logic [15:0] csum_in;
    key_t        key;
  } work_t;

  typedef struct packed {
    status_t     status;
    logic        send;
    logic [1:0]  iface;
    logic        tex;
    logic [7:0]  ttl_out;
    logic [15:0] csum_out;
  } result_t;

  function automatic iface_t pick_route(input cfg_t cfg, input logic [31:0] addr);
    iface_t r;
    if (cfg.route_enable[0] &&
        ((addr & cfg.route0_mask) == (cfg.route0_net & cfg.route0_mask))) begin
      r = IFACE_ROUTE0;
    end else if (cfg.route_enable[1] &&
                 ((addr & cfg.route1_mask) == (cfg.route1_net & cfg.route1_mask))) begin
      r = IFACE_ROUTE1;
    end else if (cfg.route_enable[2]) begin
      r = IFACE_DEFAULT;
    end else begin
      r = IFACE_NONE;
    end
    return r;
  endfunction

endpackage

FILE: src/ip_forward_dedup_engine.sv
// Top level of the IPv4 forwarding engine with timed duplicate filter.
//
// Input channel (in_valid/in_stall plus one port per header field) carries
// either a header summary to forward or to output locally, or a tick that
// ages the duplicate cache. Every input transfer yields exactly one result
// transfer on the output channel (out_valid/out_stall), in order.
// Configuration registers are written through cfg_write/cfg_index/cfg_data;
// the user writes them only while the engine is idle, not enforced by the block.
// A result passes a queue slot, then the cache lookup into the output register.
// Throughput: one item per cycle while out_stall stays low, set by the cache
// compare/replace in the back end.
// The front end classifies (local, routes, TTL and checksum) and pushes into
// a short queue; in_stall rises only when that queue is full, so the front
// keeps taking items while a finished result waits on out_stall.
// Reset (rst, synchronous): cache timers cleared (all entries free), queue
// and output register emptied, registers back to their reset values with
// hold_ticks at 20.
module ip_forward_dedup_engine #(
  parameter int CACHE_ENTRIES = ipfd_pkg::CACHE_ENTRIES_DEF,
  parameter int QUEUE_DEPTH   = ipfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ipfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [15:0]                     pkt_len,
  input  logic [15:0]                     frag_offset,
  input  logic [15:0]                     ip_ident,
  input  logic [31:0]                     src_addr,
  input  logic [31:0]                     dst_addr,
  input  logic [7:0]                      protocol,
  input  logic [31:0]                     port_word,
  input  logic [7:0]                      ttl_in,
  input  logic [15:0]                     checksum_in,
  input  logic [7:0]                      icmp_type,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic                            send,
  output logic [1:0]                      iface,
  output logic                            expired_reply,
  output logic [7:0]                      ttl_out,
  output logic [15:0]                     checksum_out
);

  ipfd_pkg::cfg_t    cfg;
  ipfd_pkg::work_t   push_item;
  ipfd_pkg::work_t   pop_item;
  ipfd_pkg::result_t res;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{hold_ticks: ipfd_pkg::HOLD_TICKS_RST, default: '0};
    end else if (cfg_write) begin
      unique case (ipfd_pkg::cfg_reg_t'(cfg_index))
        ipfd_pkg::CFG_HOST_ADDR:   cfg.host_addr      <= cfg_data;
        ipfd_pkg::CFG_ROUTE0_NET:  cfg.route0_net     <= cfg_data;
        ipfd_pkg::CFG_ROUTE0_MASK: cfg.route0_mask    <= cfg_data;
        ipfd_pkg::CFG_ROUTE1_NET:  cfg.route1_net     <= cfg_data;
        ipfd_pkg::CFG_ROUTE1_MASK: cfg.route1_mask    <= cfg_data;
        ipfd_pkg::CFG_ROUTE_EN:    cfg.route_enable   <= cfg_data[2:0];
        ipfd_pkg::CFG_HOLD_TICKS:  cfg.hold_ticks     <= cfg_data[15:0];
        ipfd_pkg::CFG_PING_CONF:   cfg.ping_addr_conf <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: transfer acceptance and classification
  ipfd_front u_front (
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .pkt_len     (pkt_len),
    .frag_offset (frag_offset),
    .ip_ident    (ip_ident),
    .src_addr    (src_addr),
    .dst_addr    (dst_addr),
    .protocol    (protocol),
    .port_word   (port_word),
    .ttl_in      (ttl_in),
    .checksum_in (checksum_in),
    .icmp_type   (icmp_type),
    .queue_full  (q_full),
    .push        (push),
    .item        (push_item)
  );

  // decoupling queue
  ipfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (push_item),
    .pop      (pop),
    .item_out (pop_item),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: duplicate cache and result register
  ipfd_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .hold_ticks (cfg.hold_ticks),
    .q_empty    (q_empty),
    .item       (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign status        = res.status;
  assign send          = res.send;
  assign iface         = res.iface;
  assign expired_reply = res.tex;
  assign ttl_out       = res.ttl_out;
  assign checksum_out  = res.csum_out;

  // a packet goes out exactly when the status says sent
  a_sent_matches_send: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ipfd_pkg::ST_SENT) == send))
    else $error("status and send disagree");

  // a time-exceeded reply is always a sent packet
  a_tex_implies_send: assert property (@(posedge clk) disable iff (rst)
    (out_valid && expired_reply) |-> send)
    else $error("expired_reply without send");

  // no interface is named when nothing is sent
  a_iface_zero_unsent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !send) |-> (iface == 2'd0))
    else $error("iface set on unsent result");

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

FILE: src/ipfd_front.sv
// Front end: takes input transfers and classifies them against the configuration.
module ipfd_front (
  input  ipfd_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [15:0]       pkt_len,
  input  logic [15:0]       frag_offset,
  input  logic [15:0]       ip_ident,
  input  logic [31:0]       src_addr,
  input  logic [31:0]       dst_addr,
  input  logic [7:0]        protocol,
  input  logic [31:0]       port_word,
  input  logic [7:0]        ttl_in,
  input  logic [15:0]       checksum_in,
  input  logic [7:0]        icmp_type,
  input  logic              queue_full,
  output logic              push,
  output ipfd_pkg::work_t   item
);

  ipfd_pkg::iface_t route_dst;
  ipfd_pkg::iface_t route_src;
  logic [7:0]       ttl_dec;
  logic [15:0]      csum_upd;
  logic             is_local;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  assign route_dst = ipfd_pkg::pick_route(cfg, dst_addr);
  assign route_src = ipfd_pkg::pick_route(cfg, src_addr);
  assign ttl_dec   = ttl_in - 8'd1;
  // TTL sits in the high byte: one's complement add of 0x0100 with end-around carry
  assign csum_upd  = (checksum_in >= ipfd_pkg::CSUM_WRAP_LIMIT) ?
                     checksum_in + ipfd_pkg::CSUM_TTL_STEP + 16'd1 :
                     checksum_in + ipfd_pkg::CSUM_TTL_STEP;
  assign is_local  = (dst_addr == cfg.host_addr) ||
                     (cfg.ping_addr_conf && (cfg.host_addr == 32'd0) &&
                      (protocol == ipfd_pkg::PROTO_ICMP) &&
                      (icmp_type == ipfd_pkg::ICMP_ECHO_REQ));

  always_comb begin
    item                 = '0;
    item.status          = ipfd_pkg::ST_IGNORED;
    item.ttl_out         = ttl_in;
    item.csum_out        = checksum_in;
    item.ttl_in          = ttl_in;
    item.csum_in         = checksum_in;
    item.key.src_addr    = src_addr;
    item.key.dst_addr    = dst_addr;
    item.key.pkt_len     = pkt_len;
    item.key.frag_offset = frag_offset;
    item.key.ip_ident    = ip_ident;
    item.key.protocol    = protocol;
    item.key.port_word   = port_word;
    unique case (ipfd_pkg::func_t'(func))
      ipfd_pkg::FUNC_TICK: begin
        item.tick     = 1'b1;
        item.status   = ipfd_pkg::ST_TICK;
        item.ttl_out  = 8'd0;
        item.csum_out = 16'd0;
      end
      ipfd_pkg::FUNC_OUTPUT: begin
        if (pkt_len == 16'd0) begin
          item.status = ipfd_pkg::ST_ZEROLEN;
        end else if (route_dst == ipfd_pkg::IFACE_NONE) begin
          item.status = ipfd_pkg::ST_NOROUTE;
        end else begin
          item.record = 1'b1;
          item.status = ipfd_pkg::ST_SENT;
          item.send   = 1'b1;
          item.iface  = route_dst;
        end
      end
      ipfd_pkg::FUNC_FORWARD: begin
        if (is_local) begin
          item.status = ipfd_pkg::ST_LOCAL;
        end else begin
          // result assuming no cache hit; the back end overrides on a hit
          item.check_dup = 1'b1;
          item.ttl_out   = ttl_dec;
          item.csum_out  = csum_upd;
          if (ttl_dec == 8'd0) begin
            if (protocol == ipfd_pkg::PROTO_ICMP) begin
              item.status = ipfd_pkg::ST_SILENT;
            end else if (route_src == ipfd_pkg::IFACE_NONE) begin
              item.status = ipfd_pkg::ST_NOROUTE;
            end else begin
              item.status = ipfd_pkg::ST_SENT;
              item.send   = 1'b1;
              item.iface  = route_src;
              item.tex    = 1'b1;
            end
          end else if (pkt_len == 16'd0) begin
            item.status = ipfd_pkg::ST_ZEROLEN;
          end else if (route_dst == ipfd_pkg::IFACE_NONE) begin
            item.status = ipfd_pkg::ST_NOROUTE;
          end else begin
            item.record = 1'b1;
            item.status = ipfd_pkg::ST_SENT;
            item.send   = 1'b1;
            item.iface  = route_dst;
          end
        end
      end
      default: begin
        item.status = ipfd_pkg::ST_IGNORED;
      end
    endcase
  end

endmodule

FILE: src/ipfd_queue.sv
// Short in-order queue of classified items between front and back end.
module ipfd_queue #(
  parameter int DEPTH = ipfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ipfd_pkg::work_t item_in,
  input  logic            pop,
  output ipfd_pkg::work_t item_out,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ipfd_pkg::work_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign item_out = slots[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= item_in;
  end

endmodule

FILE: src/ipfd_back.sv
// Back end: duplicate cache lookup, recording, aging and the output register.
module ipfd_back #(
  parameter int CACHE_ENTRIES = ipfd_pkg::CACHE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       hold_ticks,
  input  logic              q_empty,
  input  ipfd_pkg::work_t   item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output ipfd_pkg::result_t res
);

  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int P  = 1 << IW;

  logic [15:0]    timer     [CACHE_ENTRIES];
  ipfd_pkg::key_t entry_key [CACHE_ENTRIES];

  logic [CACHE_ENTRIES-1:0] hit_vec;
  logic                     dup;
  logic                     free_found;
  logic [IW-1:0]            free_idx;
  logic [IW-1:0]            victim;
  logic                     do_record;
  logic                     do_tick;

  logic [15:0]   node_val [2*P];
  logic [IW-1:0] node_idx [2*P];
  logic          node_ok  [2*P];

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      hit_vec[i] = (timer[i] != 16'd0) && (entry_key[i] == item.key);
    end
  end

  assign dup = item.check_dup && (|hit_vec);

  // lowest free entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (timer[i] == 16'd0) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // min-timer tree, ties go to the higher index
  always_comb begin
    for (int k = 0; k < 2*P; k++) begin
      node_val[k] = '1;
      node_idx[k] = '0;
      node_ok[k]  = 1'b0;
    end
    for (int j = 0; j < P; j++) begin
      node_idx[P+j] = IW'(j);
      if (j < CACHE_ENTRIES) begin
        node_val[P+j] = timer[j];
        node_ok[P+j]  = 1'b1;
      end
    end
    for (int k = P - 1; k >= 1; k--) begin
      if (node_ok[2*k+1] && (!node_ok[2*k] || (node_val[2*k+1] <= node_val[2*k]))) begin
        node_val[k] = node_val[2*k+1];
        node_idx[k] = node_idx[2*k+1];
        node_ok[k]  = 1'b1;
      end else begin
        node_val[k] = node_val[2*k];
        node_idx[k] = node_idx[2*k];
        node_ok[k]  = node_ok[2*k];
      end
    end
  end

  assign victim    = free_found ? free_idx : node_idx[1];
  assign do_record = pop && item.record && !dup;
  assign do_tick   = pop && item.tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) timer[i] <= '0;
    end else if (do_tick) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (timer[i] != 16'd0) timer[i] <= timer[i] - 16'd1;
      end
    end else if (do_record) begin
      timer[victim] <= hold_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (do_record) entry_key[victim] <= item.key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (dup) begin
        res.status   <= ipfd_pkg::ST_DUP;
        res.send     <= 1'b0;
        res.iface    <= 2'd0;
        res.tex      <= 1'b0;
        res.ttl_out  <= item.ttl_in;
        res.csum_out <= item.csum_in;
      end else begin
        res.status   <= item.status;
        res.send     <= item.send;
        res.iface    <= item.iface;
        res.tex      <= item.tex;
        res.ttl_out  <= item.ttl_out;
        res.csum_out <= item.csum_out;
      end
    end
  end

endmodule
